// ===== rtl/bfc_pkg.sv =====
// ----------------------------------------------------------------------------
// bfc_pkg - shared definitions for the binary frame capture filter
// Holds the sync constants, request, verdict and register codes, default
// sizes, the configuration register set and the parser event record.
// ----------------------------------------------------------------------------
package bfc_pkg;

  // Default sizes, handed to the top level parameters
  localparam int MAX_FRAME_DEF     = 512;
  localparam int CAPTURE_DEPTH_DEF = 4096;

  // Fixed field widths
  localparam int LEN_W      = 13;
  localparam int COUNT_W    = 16;
  localparam int READ_IDX_W = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Frame sync bytes and filter wildcard
  localparam logic [7:0] SYNC_A   = 8'hB5;
  localparam logic [7:0] SYNC_B   = 8'h62;
  localparam logic [7:0] WILDCARD = 8'hFF;

  // Request codes
  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;

  // Verdict codes
  localparam logic [2:0] VERDICT_NONE     = 3'd0;
  localparam logic [2:0] VERDICT_STORED   = 3'd1;
  localparam logic [2:0] VERDICT_END      = 3'd2;
  localparam logic [2:0] VERDICT_FILTERED = 3'd3;
  localparam logic [2:0] VERDICT_NO_ROOM  = 3'd4;
  localparam logic [2:0] VERDICT_LEN_DROP = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_CLASS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_ID    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CLASS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_ID      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT       = 3'd5;

  localparam logic [LEN_W-1:0] LIMIT_RESET = 13'd4096;

  typedef struct packed {
    logic             enable;
    logic [7:0]       match_class;
    logic [7:0]       match_id;
    logic [7:0]       end_class;
    logic [7:0]       end_id;
    logic [LEN_W-1:0] limit;
  } cfg_regs_t;

  // What the parser reports for one received byte
  typedef struct packed {
    logic       claimed;
    logic       wr_en;
    logic       done;
    logic       len_drop;
    logic [7:0] cls;
    logic [7:0] id;
  } frame_evt_t;

endpackage

// ===== rtl/bfc_if.sv =====
// ----------------------------------------------------------------------------
// bfc_if - channel interfaces of the binary frame capture filter
// Input request channel, result channel and configuration write channel,
// each with valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface bfc_in_if
  import bfc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [1:0]            req_type;
  logic [7:0]            data_byte;
  logic [READ_IDX_W-1:0] read_index;

  modport source (output valid, output req_type, output data_byte, output read_index,
                  input ready);
  modport sink   (input valid, input req_type, input data_byte, input read_index,
                  output ready);
endinterface

interface bfc_out_if
  import bfc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               claimed;
  logic               frame_end;
  logic [2:0]         verdict;
  logic [7:0]         read_data;
  logic               read_valid;
  logic [LEN_W-1:0]   captured_bytes;
  logic [COUNT_W-1:0] frames_kept;
  logic               capture_finished;

  modport source (output valid, output claimed, output frame_end, output verdict,
                  output read_data, output read_valid, output captured_bytes,
                  output frames_kept, output capture_finished, input ready);
  modport sink   (input valid, input claimed, input frame_end, input verdict,
                  input read_data, input read_valid, input captured_bytes,
                  input frames_kept, input capture_finished, output ready);
endinterface

interface bfc_cfg_if
  import bfc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/bfc_parser.sv =====
// ----------------------------------------------------------------------------
// bfc_parser - binary frame parser
// Tracks sync, class, id, length, payload and checksum bytes of a frame,
// flags claimed bytes and gives the offset of each frame byte in the frame.
// ----------------------------------------------------------------------------
module bfc_parser
  import bfc_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF,
  parameter int FB_W      = $clog2(MAX_FRAME + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_go,
  input  logic [7:0]      byte_in,
  output frame_evt_t      evt,
  output logic [FB_W-1:0] wr_off,
  output logic [FB_W-1:0] fb_total
);

  localparam int          PS_W    = $clog2(MAX_FRAME);
  localparam logic [15:0] LEN_MAX = 16'(MAX_FRAME - 8);

  localparam logic [3:0] PH_HUNT    = 4'd0;
  localparam logic [3:0] PH_SYNC2   = 4'd1;
  localparam logic [3:0] PH_CLASS   = 4'd2;
  localparam logic [3:0] PH_ID      = 4'd3;
  localparam logic [3:0] PH_LENLO   = 4'd4;
  localparam logic [3:0] PH_LENHI   = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CKA     = 4'd7;
  localparam logic [3:0] PH_CKB     = 4'd8;

  logic [3:0]      phase_r, phase_nxt;
  logic [7:0]      cls_r, cls_nxt;
  logic [7:0]      id_r, id_nxt;
  logic [7:0]      len_lo_r, len_lo_nxt;
  logic [PS_W-1:0] plen_r, plen_nxt;
  logic [PS_W-1:0] seen_r, seen_nxt;
  logic [FB_W-1:0] fb_r, fb_nxt;
  logic [15:0]     full_len;
  logic [PS_W-1:0] seen_inc;

  assign full_len = {byte_in, len_lo_r};
  assign seen_inc = seen_r + 1'b1;
  assign fb_total = fb_r + 1'b1;

  // Advance the frame state on each received byte
  always_comb begin
    phase_nxt  = phase_r;
    cls_nxt    = cls_r;
    id_nxt     = id_r;
    len_lo_nxt = len_lo_r;
    plen_nxt   = plen_r;
    seen_nxt   = seen_r;
    fb_nxt     = fb_r;
    wr_off     = fb_r;
    evt        = '0;
    evt.cls    = cls_r;
    evt.id     = id_r;
    if (byte_go) begin
      evt.claimed = 1'b1;
      evt.wr_en   = 1'b1;
      fb_nxt      = fb_r + 1'b1;
      unique case (phase_r)
        PH_HUNT: begin
          wr_off = '0;
          if (byte_in == SYNC_A) begin
            phase_nxt = PH_SYNC2;
            fb_nxt    = FB_W'(1);
          end else begin
            evt.claimed = 1'b0;
            evt.wr_en   = 1'b0;
            fb_nxt      = fb_r;
          end
        end
        PH_SYNC2: begin
          if (byte_in == SYNC_B) begin
            phase_nxt = PH_CLASS;
          end else begin
            phase_nxt   = PH_HUNT;
            evt.claimed = 1'b0;
            evt.wr_en   = 1'b0;
            fb_nxt      = fb_r;
          end
        end
        PH_CLASS: begin
          cls_nxt   = byte_in;
          phase_nxt = PH_ID;
        end
        PH_ID: begin
          id_nxt    = byte_in;
          phase_nxt = PH_LENLO;
        end
        PH_LENLO: begin
          len_lo_nxt = byte_in;
          phase_nxt  = PH_LENHI;
        end
        PH_LENHI: begin
          seen_nxt = '0;
          plen_nxt = full_len[PS_W-1:0];
          if (full_len > LEN_MAX) begin
            // oversized: drop here and hunt again
            phase_nxt    = PH_HUNT;
            evt.len_drop = 1'b1;
          end else if (full_len == 16'd0) begin
            phase_nxt = PH_CKA;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          seen_nxt = seen_inc;
          if (seen_inc >= plen_r) begin
            phase_nxt = PH_CKA;
          end
        end
        PH_CKA: begin
          phase_nxt = PH_CKB;
        end
        PH_CKB: begin
          phase_nxt = PH_HUNT;
          evt.done  = 1'b1;
        end
        default: begin
          phase_nxt   = PH_HUNT;
          evt.claimed = 1'b0;
          evt.wr_en   = 1'b0;
          fb_nxt      = fb_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      cls_r    <= '0;
      id_r     <= '0;
      len_lo_r <= '0;
      plen_r   <= '0;
      seen_r   <= '0;
      fb_r     <= '0;
    end else begin
      phase_r  <= phase_nxt;
      cls_r    <= cls_nxt;
      id_r     <= id_nxt;
      len_lo_r <= len_lo_nxt;
      plen_r   <= plen_nxt;
      seen_r   <= seen_nxt;
      fb_r     <= fb_nxt;
    end
  end

endmodule

// ===== rtl/bfc_store.sv =====
// ----------------------------------------------------------------------------
// bfc_store - capture store
// Byte-wide synchronous memory, one write and one read port, registered
// read data, available in the cycle after the read is issued.
// ----------------------------------------------------------------------------
module bfc_store
  import bfc_pkg::*;
#(
  parameter int CAPTURE_DEPTH = CAPTURE_DEPTH_DEF,
  parameter int AW            = $clog2(CAPTURE_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] store_mem [0:CAPTURE_DEPTH-1];
  logic [7:0] rdata_r;

  // Write frame bytes, read captured bytes
  always_ff @(posedge clk) begin
    if (we) begin
      store_mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= store_mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bfc_capture.sv =====
// ----------------------------------------------------------------------------
// bfc_capture - capture bookkeeping
// Places frame bytes in the uncommitted tail of the store, decides the
// verdict at frame end, commits kept frames and maps read indexes.
// ----------------------------------------------------------------------------
module bfc_capture
  import bfc_pkg::*;
#(
  parameter int CAPTURE_DEPTH = CAPTURE_DEPTH_DEF,
  parameter int MAX_FRAME     = MAX_FRAME_DEF,
  parameter int FB_W          = $clog2(MAX_FRAME + 1),
  parameter int AW            = $clog2(CAPTURE_DEPTH + MAX_FRAME)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_regs_t             cfg,
  input  logic                  read_go,
  input  logic                  start_go,
  input  frame_evt_t            evt,
  input  logic [FB_W-1:0]       wr_off,
  input  logic [FB_W-1:0]       fb_total,
  input  logic [READ_IDX_W-1:0] read_index,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_raddr,
  output logic [2:0]            verdict,
  output logic                  read_valid,
  output logic [LEN_W-1:0]      captured_bytes,
  output logic [COUNT_W-1:0]    frames_kept,
  output logic                  capture_finished
);

  // The store ring holds the capture depth plus one whole frame, so the frame
  // being received never lands on committed bytes
  localparam int RING  = CAPTURE_DEPTH + MAX_FRAME;
  localparam int SUM_W = ((AW + 1) > (LEN_W + 1)) ? (AW + 1) : (LEN_W + 1);
  localparam int PW    = ((AW > FB_W) ? AW : FB_W) + 1;
  localparam int RW    = ((AW > READ_IDX_W) ? AW : READ_IDX_W) + 1;

  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(CAPTURE_DEPTH);
  localparam logic [PW-1:0]    RING_P  = PW'(RING);
  localparam logic [RW-1:0]    RING_R  = RW'(RING);

  // Logical byte 0 of the capture sits at origin_r; the next frame starts at base_r
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               end_r, end_nxt;
  logic [AW-1:0]      origin_r, origin_nxt;
  logic [AW-1:0]      base_r, base_nxt;

  logic [SUM_W-1:0] need, lim, limit_s, idx_s;
  logic [PW-1:0]    wr_sum, wr_phys, cm_sum, cm_phys;
  logic [RW-1:0]    rd_sum, rd_phys;
  logic             end_match, filt_fail;

  // Place frame bytes in the spare tail after the committed data
  assign wr_sum    = PW'(base_r) + PW'(wr_off);
  assign wr_phys   = (wr_sum >= RING_P) ? (wr_sum - RING_P) : wr_sum;
  assign mem_we    = evt.wr_en;
  assign mem_waddr = wr_phys[AW-1:0];

  // Map a read index onto the store
  assign idx_s      = SUM_W'(read_index);
  assign rd_sum     = RW'(origin_r) + RW'(read_index);
  assign rd_phys    = (rd_sum >= RING_R) ? (rd_sum - RING_R) : rd_sum;
  assign read_valid = read_go && (idx_s < SUM_W'(len_r)) && (idx_s < DEPTH_S);
  assign mem_re     = read_valid;
  assign mem_raddr  = rd_phys[AW-1:0];

  // Room check and commit position
  assign need    = SUM_W'(len_r) + SUM_W'(fb_total);
  assign limit_s = SUM_W'(cfg.limit);
  assign lim     = (limit_s < DEPTH_S) ? limit_s : DEPTH_S;
  assign cm_sum  = PW'(base_r) + PW'(fb_total);
  assign cm_phys = (cm_sum >= RING_P) ? (cm_sum - RING_P) : cm_sum;

  assign end_match = (evt.cls == cfg.end_class) && (evt.id == cfg.end_id);
  assign filt_fail = ((cfg.match_class != WILDCARD) && (evt.cls != cfg.match_class)) ||
                     ((cfg.match_id != WILDCARD) && (evt.id != cfg.match_id));

  // Decide the verdict and update the counters
  always_comb begin
    len_nxt    = len_r;
    count_nxt  = count_r;
    end_nxt    = end_r;
    origin_nxt = origin_r;
    base_nxt   = base_r;
    verdict    = VERDICT_NONE;
    if (evt.len_drop) begin
      verdict = VERDICT_LEN_DROP;
    end
    if (evt.done && cfg.enable && !end_r) begin
      if (end_match) begin
        verdict = VERDICT_END;
        end_nxt = 1'b1;
      end else if (filt_fail) begin
        verdict = VERDICT_FILTERED;
      end else if (need > lim) begin
        verdict = VERDICT_NO_ROOM;
      end else begin
        verdict   = VERDICT_STORED;
        len_nxt   = need[LEN_W-1:0];
        count_nxt = (count_r == {COUNT_W{1'b1}}) ? count_r : count_r + 1'b1;
        base_nxt  = cm_phys[AW-1:0];
      end
    end
    // Restart: the store origin moves to the next frame position
    if (start_go) begin
      len_nxt    = '0;
      count_nxt  = '0;
      end_nxt    = 1'b0;
      origin_nxt = base_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      count_r  <= '0;
      end_r    <= 1'b0;
      origin_r <= '0;
      base_r   <= '0;
    end else begin
      len_r    <= len_nxt;
      count_r  <= count_nxt;
      end_r    <= end_nxt;
      origin_r <= origin_nxt;
      base_r   <= base_nxt;
    end
  end

  assign captured_bytes   = len_nxt;
  assign frames_kept      = count_nxt;
  assign capture_finished = end_nxt;

endmodule

// ===== rtl/binary_frame_capture_filter.sv =====
// ----------------------------------------------------------------------------
// binary_frame_capture_filter - binary frame receiver with capture store
// The request stage registers each request's outcome for the output register.
// Throughput: one request per cycle; a stalled result holds the output register
// and the request stage, which then holds the input. The store is written and
// read at most once per cycle. Reset clears parser state, counters and valid
// flags and sets the register defaults; the store is not cleared, as only
// committed bytes are read back.
// ----------------------------------------------------------------------------
module binary_frame_capture_filter
  import bfc_pkg::*;
#(
  parameter int MAX_FRAME     = MAX_FRAME_DEF,
  parameter int CAPTURE_DEPTH = CAPTURE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bfc_in_if.sink    in_chan,
  bfc_out_if.source out_chan,
  bfc_cfg_if.sink   cfg_chan
);

  localparam int FB_W       = $clog2(MAX_FRAME + 1);
  localparam int RING_DEPTH = CAPTURE_DEPTH + MAX_FRAME;
  localparam int AW         = $clog2(RING_DEPTH);

  typedef struct packed {
    logic               claimed;
    logic               frame_end;
    logic [2:0]         verdict;
    logic               read_valid;
    logic [LEN_W-1:0]   captured_bytes;
    logic [COUNT_W-1:0] frames_kept;
    logic               capture_finished;
  } stat_t;

  cfg_regs_t cfg_r, cfg_nxt;

  logic       s1_valid_r, s1_valid_nxt;
  stat_t      s1_stat_r;
  logic       out_valid_r, out_valid_nxt;
  stat_t      out_stat_r;
  logic [7:0] out_rdata_r;

  logic       s1_move, in_ready, in_go;
  logic       byte_go, read_go, start_go;
  stat_t      stat;

  frame_evt_t      evt;
  logic [FB_W-1:0] wr_off, fb_total;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [7:0]      mem_rdata;

  // Register writes are always taken
  assign cfg_chan.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_ENABLE:      cfg_nxt.enable      = cfg_chan.wdata[0];
        CFG_MATCH_CLASS: cfg_nxt.match_class = cfg_chan.wdata[7:0];
        CFG_MATCH_ID:    cfg_nxt.match_id    = cfg_chan.wdata[7:0];
        CFG_END_CLASS:   cfg_nxt.end_class   = cfg_chan.wdata[7:0];
        CFG_END_ID:      cfg_nxt.end_id      = cfg_chan.wdata[7:0];
        CFG_LIMIT:       cfg_nxt.limit       = cfg_chan.wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Hand-off: the request stage moves on when the output register frees up
  assign s1_move       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_ready      = !s1_valid_r || s1_move;
  assign in_chan.ready = in_ready;
  assign in_go         = in_chan.valid && in_ready;
  assign byte_go       = in_go && (in_chan.req_type == REQ_BYTE);
  assign read_go       = in_go && (in_chan.req_type == REQ_READ);
  assign start_go      = in_go && (in_chan.req_type == REQ_START);

  bfc_parser #(
    .MAX_FRAME (MAX_FRAME),
    .FB_W      (FB_W)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_go  (byte_go),
    .byte_in  (in_chan.data_byte),
    .evt      (evt),
    .wr_off   (wr_off),
    .fb_total (fb_total)
  );

  bfc_capture #(
    .CAPTURE_DEPTH (CAPTURE_DEPTH),
    .MAX_FRAME     (MAX_FRAME),
    .FB_W          (FB_W),
    .AW            (AW)
  ) u_capture (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .read_go          (read_go),
    .start_go         (start_go),
    .evt              (evt),
    .wr_off           (wr_off),
    .fb_total         (fb_total),
    .read_index       (in_chan.read_index),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_re           (mem_re),
    .mem_raddr        (mem_raddr),
    .verdict          (stat.verdict),
    .read_valid       (stat.read_valid),
    .captured_bytes   (stat.captured_bytes),
    .frames_kept      (stat.frames_kept),
    .capture_finished (stat.capture_finished)
  );

  assign stat.claimed   = evt.claimed;
  assign stat.frame_end = evt.done;

  bfc_store #(
    .CAPTURE_DEPTH (RING_DEPTH),
    .AW            (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_chan.data_byte),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Valid flags of the request stage and the output register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_go) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r             <= '0;
      cfg_r.match_class <= WILDCARD;
      cfg_r.match_id    <= WILDCARD;
      cfg_r.end_class   <= WILDCARD;
      cfg_r.end_id      <= WILDCARD;
      cfg_r.limit       <= LIMIT_RESET;
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold results; store read data joins a result as it moves to the output register
  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_stat_r <= stat;
    end
    if (s1_move) begin
      out_stat_r  <= s1_stat_r;
      out_rdata_r <= s1_stat_r.read_valid ? mem_rdata : 8'd0;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.claimed          = out_stat_r.claimed;
  assign out_chan.frame_end        = out_stat_r.frame_end;
  assign out_chan.verdict          = out_stat_r.verdict;
  assign out_chan.read_data        = out_rdata_r;
  assign out_chan.read_valid       = out_stat_r.read_valid;
  assign out_chan.captured_bytes   = out_stat_r.captured_bytes;
  assign out_chan.frames_kept      = out_stat_r.frames_kept;
  assign out_chan.capture_finished = out_stat_r.capture_finished;

endmodule

// ===== rtl/bfc_checker.sv =====
// ----------------------------------------------------------------------------
// bfc_checker - port-level checks for the binary frame capture filter
// Watches the request and result channels and the result fields over time.
// ----------------------------------------------------------------------------
module bfc_checker
  import bfc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       claimed,
  input logic       frame_end,
  input logic [2:0] verdict,
  input logic [7:0] read_data,
  input logic       read_valid
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({claimed, frame_end, verdict, read_data, read_valid}))
    else $error("result changed while stalled");

  // A fresh result follows an earlier request transfer through the request stage
  a_out_follows_in: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a request");

  // A completed frame is a claimed byte
  a_end_claimed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_end |-> claimed && (verdict != VERDICT_LEN_DROP))
    else $error("frame end on an unclaimed byte");

  // Capture verdicts only at frame end, length drop only mid-frame
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((verdict == VERDICT_STORED) || (verdict == VERDICT_END) ||
                  (verdict == VERDICT_FILTERED) || (verdict == VERDICT_NO_ROOM))
      |-> frame_end)
    else $error("capture verdict without frame end");

  // Out-of-range reads return zero
  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !read_valid |-> (read_data == 8'd0))
    else $error("read data without a valid read");

endmodule

bind binary_frame_capture_filter bfc_checker u_bfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .claimed    (out_chan.claimed),
  .frame_end  (out_chan.frame_end),
  .verdict    (out_chan.verdict),
  .read_data  (out_chan.read_data),
  .read_valid (out_chan.read_valid)
);
